FILE: sv/tzht_pkg.sv
package tzht_pkg;

    localparam int MAX_ZONES    = 96;
    localparam int IDX_W        = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CNT_W        = $clog2(MAX_ZONES + 1);
    localparam int ZONE_COUNT_W = 7;
    localparam int KEY_W        = 16;
    localparam int COORD_W      = 16;
    localparam int CFG_IDX_W    = 8;

    typedef enum logic [2:0] {
        OP_REGISTER    = 3'd0,
        OP_REFRESH     = 3'd1,
        OP_REMOVE      = 3'd2,
        OP_POINT_QUERY = 3'd3,
        OP_BEGIN_PRESS = 3'd4,
        OP_FINGER_DOWN = 3'd5,
        OP_PRESS_EVENT = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_KEY   = 2'd2,
        ST_NO_PULSE = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_HAPTIC_ENABLE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_PULSE_ENABLE = CFG_IDX_W'(1);

    typedef struct packed {
        op_t                        op;
        logic [KEY_W-1:0]           zone_key;
        logic signed [COORD_W-1:0]  left;
        logic signed [COORD_W-1:0]  top;
        logic signed [COORD_W-1:0]  right;
        logic signed [COORD_W-1:0]  bottom;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
    } in_item_t;

    typedef struct packed {
        logic                    pulse;
        logic                    hit;
        status_t                 status;
        logic [ZONE_COUNT_W-1:0] zone_count;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] bottom;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } rect_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic act;
        logic rd_last;
        logic move;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_search;
        logic hit_now;
        logic last_now;
        logic do_move;
    } sts_t;

endpackage

FILE: sv/tzht_ctrl.sv
module tzht_ctrl
    import tzht_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_ACT,
        S_RD_LAST,
        S_MOVE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = sts.need_search ? S_SCAN : S_ACT;
            end
            S_SCAN: begin
                if (sts.hit_now || sts.last_now) begin
                    state_next = S_ACT;
                end else begin
                    cmd.scan_en = 1'b1;
                end
            end
            S_ACT: begin
                cmd.act    = 1'b1;
                state_next = sts.do_move ? S_RD_LAST : S_FINISH;
            end
            S_RD_LAST: begin
                cmd.rd_last = 1'b1;
                state_next  = S_MOVE;
            end
            S_MOVE: begin
                cmd.move   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: sv/tzht_dp.sv
module tzht_dp
    import tzht_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  in_item_t             s_data,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    logic [KEY_W-1:0] zone_keys [MAX_ZONES];
    rect_t            zone_rects [MAX_ZONES];

    in_item_t         item_reg;
    logic [KEY_W-1:0] key_q_reg;
    rect_t            rect_q_reg;
    out_item_t        out_reg;

    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0] cmp_idx_reg;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [31:0]      press_reg, press_next;
    logic [31:0]      pulsed_reg, pulsed_next;
    logic             haptic_reg, haptic_next;
    logic             early_reg, early_next;
    logic             pend_pulse_reg, pend_pulse_next;
    logic             pend_hit_reg, pend_hit_next;
    status_t          pend_status_reg, pend_status_next;

    logic             key_zero;
    logic [CNT_W-1:0] used_m1;
    logic             in_rect;
    logic             match;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             we_key;
    logic             we_rect;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    rect_t            wr_rect;
    rect_t            item_rect;
    logic [31:0]      press_fd;

    assign key_zero  = (item_reg.zone_key == '0);
    assign used_m1   = used_reg - CNT_W'(1);
    assign item_rect = '{bottom: item_reg.bottom, right: item_reg.right,
                         top: item_reg.top, left: item_reg.left};
    assign press_fd  = (press_reg == '0) ? 32'd1 : press_reg;

    assign in_rect = (item_reg.point_x >= rect_q_reg.left) &&
                     (item_reg.point_x <= rect_q_reg.right) &&
                     (item_reg.point_y >= rect_q_reg.top) &&
                     (item_reg.point_y <= rect_q_reg.bottom);

    assign match = (item_reg.op == OP_POINT_QUERY) ? ((key_q_reg != '0) && in_rect)
                                                   : (key_q_reg == item_reg.zone_key);

    always_comb begin
        sts.need_search = 1'b0;
        if (used_reg != '0) begin
            case (item_reg.op)
                OP_REGISTER, OP_REFRESH, OP_REMOVE, OP_PRESS_EVENT: begin
                    sts.need_search = !key_zero;
                end
                OP_POINT_QUERY: begin
                    sts.need_search = haptic_reg && early_reg;
                end
                default: begin
                    sts.need_search = 1'b0;
                end
            endcase
        end
        sts.hit_now  = cmp_valid_reg && match;
        sts.last_now = cmp_valid_reg && (cmp_idx_reg == used_m1);
        sts.do_move  = (item_reg.op == OP_REMOVE) && found_reg;
    end

    assign rd_en   = (cmd.scan_en && (idx_reg < CNT_W'(MAX_ZONES))) || cmd.rd_last;
    assign rd_addr = cmd.rd_last ? used_m1[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    always_comb begin
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        idx_next         = idx_reg;
        cmp_valid_next   = 1'b0;
        used_next        = used_reg;
        press_next       = press_reg;
        pulsed_next      = pulsed_reg;
        haptic_next      = haptic_reg;
        early_next       = early_reg;
        pend_pulse_next  = pend_pulse_reg;
        pend_hit_next    = pend_hit_reg;
        pend_status_next = pend_status_reg;
        we_key           = 1'b0;
        we_rect          = 1'b0;
        wr_addr          = found_idx_reg;
        wr_key           = item_reg.zone_key;
        wr_rect          = item_rect;

        if (cfg_valid) begin
            if (cfg_index == CFG_HAPTIC_ENABLE) begin
                haptic_next = cfg_data;
            end else if (cfg_index == CFG_EARLY_PULSE_ENABLE) begin
                early_next = cfg_data;
            end
        end

        if (cmd.load) begin
            found_next = 1'b0;
            idx_next   = '0;
        end

        if (cmd.scan_en) begin
            idx_next       = idx_reg + CNT_W'(1);
            cmp_valid_next = 1'b1;
        end

        if (sts.hit_now) begin
            found_next     = 1'b1;
            found_idx_next = cmp_idx_reg[IDX_W-1:0];
        end

        if (cmd.act) begin
            pend_pulse_next  = 1'b0;
            pend_hit_next    = 1'b0;
            pend_status_next = ST_DONE;
            case (item_reg.op)
                OP_REGISTER: begin
                    if (key_zero) begin
                        pend_status_next = ST_NO_KEY;
                    end else if (found_reg) begin
                        we_rect = 1'b1;
                    end else if (used_reg >= CNT_W'(MAX_ZONES)) begin
                        pend_status_next = ST_FULL;
                    end else begin
                        we_key    = 1'b1;
                        we_rect   = 1'b1;
                        wr_addr   = used_reg[IDX_W-1:0];
                        used_next = used_reg + CNT_W'(1);
                    end
                end
                OP_REFRESH: begin
                    if (found_reg) begin
                        we_rect = 1'b1;
                    end else begin
                        pend_status_next = ST_NO_KEY;
                    end
                end
                OP_REMOVE: begin
                    if (!found_reg) begin
                        pend_status_next = ST_NO_KEY;
                    end
                end
                OP_POINT_QUERY: begin
                    pend_status_next = ST_NO_PULSE;
                    if (found_reg) begin
                        press_next       = press_fd;
                        pulsed_next      = press_fd;
                        pend_hit_next    = 1'b1;
                        pend_pulse_next  = haptic_reg;
                        pend_status_next = haptic_reg ? ST_DONE : ST_NO_PULSE;
                    end
                end
                OP_BEGIN_PRESS: begin
                    press_next  = press_reg + 32'd1;
                    pulsed_next = '0;
                end
                OP_FINGER_DOWN: begin
                    press_next       = press_fd;
                    pulsed_next      = press_fd;
                    pend_pulse_next  = haptic_reg;
                    pend_status_next = haptic_reg ? ST_DONE : ST_NO_PULSE;
                end
                OP_PRESS_EVENT: begin
                    we_rect = found_reg;
                    if ((press_reg != '0) && (pulsed_reg == press_reg)) begin
                        pend_status_next = ST_NO_PULSE;
                    end else begin
                        if (press_reg != '0) begin
                            pulsed_next = press_reg;
                        end
                        pend_pulse_next  = haptic_reg;
                        pend_status_next = haptic_reg ? ST_DONE : ST_NO_PULSE;
                    end
                end
                default: begin
                    pend_status_next = ST_DONE;
                end
            endcase
        end

        if (cmd.move) begin
            we_key    = 1'b1;
            we_rect   = 1'b1;
            wr_addr   = found_idx_reg;
            wr_key    = key_q_reg;
            wr_rect   = rect_q_reg;
            used_next = used_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we_key) begin
            zone_keys[wr_addr] <= wr_key;
        end
        if (we_rect) begin
            zone_rects[wr_addr] <= wr_rect;
        end
        if (rd_en) begin
            key_q_reg  <= zone_keys[rd_addr];
            rect_q_reg <= zone_rects[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            used_reg      <= '0;
            press_reg     <= '0;
            pulsed_reg    <= '0;
            haptic_reg    <= 1'b1;
            early_reg     <= 1'b1;
        end else begin
            found_reg     <= found_next;
            cmp_valid_reg <= cmp_valid_next;
            used_reg      <= used_next;
            press_reg     <= press_next;
            pulsed_reg    <= pulsed_next;
            haptic_reg    <= haptic_next;
            early_reg     <= early_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_idx_reg   <= found_idx_next;
        idx_reg         <= idx_next;
        cmp_idx_reg     <= idx_reg;
        pend_pulse_reg  <= pend_pulse_next;
        pend_hit_reg    <= pend_hit_next;
        pend_status_reg <= pend_status_next;
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.out_load) begin
            out_reg.pulse      <= pend_pulse_reg;
            out_reg.hit        <= pend_hit_reg;
            out_reg.status     <= pend_status_reg;
            out_reg.zone_count <= ZONE_COUNT_W'(used_reg);
        end
    end

    assign m_data = out_reg;

endmodule

FILE: sv/touch_zone_hit_table_top.sv
// Touch zone hit table. Each transaction on the s_ channel carries one operation
// (register, refresh, remove, point query, begin press, finger down, press event)
// and produces exactly one result transaction on the m_ channel with the pulse
// request, hit flag, status and the number of zones held afterwards.
// Keys and rectangles live in two tables with one read and one write port each,
// scanned one entry per cycle, with the read data registered before the compare.
// An item passes from acceptance through dispatch, an optional key or point search
// that walks the stored zones until a hit or the last one, and the action step
// to finish, where its result is loaded; a remove that finds its key adds a read
// of the last entry and a move of it into the freed slot.
// One item is processed at a time; s_ready is high only while the block is idle,
// so a new item is accepted only after the previous one has finished.
// The result sits in an output register, so the next item is accepted while it
// waits; a stalled receiver holds m_valid and m_data, and a finished item waits
// until the output register is free.
// Configuration transactions are always accepted and should be issued only when
// the block is idle. Synchronous reset empties the table, clears the press
// counters and sets both enable registers to 1; the tables need no clearing pass.
module touch_zone_hit_table_top
    import tzht_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tzht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tzht_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
